FILE: sv/assert_macros.svh
// Assertion helpers for the RTL files.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DPE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define DPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dpe_pkg.sv
package dpe_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CONC_W    = 32;
    localparam int POR_W     = 16;
    localparam int DEN_W     = POR_W + 1;
    localparam int PROD_W    = CONC_W + POR_W;
    localparam int NUM_W     = PROD_W + 2;
    localparam int AD_W      = 2 * CONC_W;
    localparam int T_FULL_W  = AD_W - FRAC_BITS;

    localparam logic [CONC_W-1:0] TS_RESET = CONC_W'(1) << FRAC_BITS;

    localparam int XCAP_INT = 32;
    localparam int X_W      = FRAC_BITS + 6;
    localparam logic [X_W-1:0] XCAP = X_W'(XCAP_INT << FRAC_BITS);
    localparam int T_W      = X_W - 1;
    localparam int TDEN_W   = T_W + DEN_W;
    localparam int XSH      = 16;
    localparam int PP_W     = 2 * POR_W;

    localparam int Q_W        = 32;
    localparam int R1_W       = DEN_W + 1;
    localparam int R2_W       = PP_W + 1;
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = Q_W / DIV_BITS;

    localparam int EXP_TERMS = 10;
    localparam int SQUARINGS = 6;
    localparam int EXP_LAT   = 3 * EXP_TERMS + SQUARINGS;
    localparam int S_W       = 31;
    localparam int U_W       = 30;
    localparam int M_W       = U_W + S_W;
    localparam int P_W       = 30;
    localparam int RCP_W     = 33;
    localparam int PQ_W      = P_W + RCP_W;
    localparam int SQ_W      = 2 * S_W;
    localparam int E_W       = FRAC_BITS + 1;
    localparam int PM_W      = CONC_W + E_W;

    localparam logic [S_W-1:0]  ONE30  = S_W'(1) << 30;
    localparam logic [SQ_W-1:0] HALF30 = SQ_W'(1) << 29;

    typedef struct packed {
        logic [CONC_W-1:0] cm;
        logic [CONC_W-1:0] ci;
        logic [PROD_W-1:0] pmcm;
        logic [PROD_W-1:0] pici;
        logic [DEN_W-1:0]  den;
        logic [AD_W-1:0]   ad;
        logic [PP_W-1:0]   pmpi;
        logic              pass;
        logic              pmz;
    } t_s2;

    typedef struct packed {
        logic [CONC_W-1:0] cm;
        logic [CONC_W-1:0] ci;
        logic [NUM_W-1:0]  num;
        logic [TDEN_W-1:0] tden;
        logic [DEN_W-1:0]  den;
        logic [PP_W-1:0]   pmpi;
        logic              tcap;
        logic              pass;
        logic              pmz;
    } t_s3;

    typedef struct packed {
        logic [CONC_W-1:0] cm;
        logic [CONC_W-1:0] ci;
        logic              pass;
        logic              pmz;
        logic              tcap;
        logic              ovf;
        logic [DEN_W-1:0]  den;
        logic [PP_W-1:0]   pmpi;
        logic [R1_W-1:0]   r1;
        logic [Q_W-1:0]    lo1;
        logic [Q_W-1:0]    q1;
        logic [R2_W-1:0]   r2;
        logic [Q_W-1:0]    lo2;
        logic [Q_W-1:0]    q2;
    } t_div;

    typedef struct packed {
        logic [CONC_W-1:0] cm;
        logic [CONC_W-1:0] ci;
        logic [CONC_W-1:0] avg;
        logic              pass;
        logic              pmz;
    } t_side;

    typedef struct packed {
        logic [CONC_W-1:0] cm;
        logic [CONC_W-1:0] ci;
        logic [CONC_W-1:0] avg;
        logic              gm;
        logic              gi;
        logic              pass;
        logic [PM_W-1:0]   pmm;
        logic [PM_W-1:0]   pmi;
    } t_rlx;

    // Reciprocal floor(2^32 / k) for the Horner divisors.
    function automatic logic [RCP_W-1:0] recip(input int k);
        logic [RCP_W-1:0] v;
        case (k)
            1:       v = 33'd4294967296;
            2:       v = 33'd2147483648;
            3:       v = 33'd1431655765;
            4:       v = 33'd1073741824;
            5:       v = 33'd858993459;
            6:       v = 33'd715827882;
            7:       v = 33'd613566756;
            8:       v = 33'd536870912;
            9:       v = 33'd477218588;
            10:      v = 33'd429496729;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/dual_porosity_exchange_unit.sv
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    conc, porosities, exchange rate
// out       output     o_out_valid / i_out_ready  new concentrations, exchanged
// cfg       input      i_cfg_valid / o_cfg_ready  time step, Q16.16
//
// One item enters per cycle unless a result held at the output stalls the pipeline.
// The longest parts of the pipeline are the two 16-stage radix-4 dividers and the 36-stage
// exponential series and squaring pipeline.
// Reset clears the valid bits and loads the time step with 1.0.
// A result held at the output stalls the whole pipeline; nothing is dropped.
`include "assert_macros.svh"

module dual_porosity_exchange_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [dpe_pkg::CONC_W-1:0]    i_mobile_conc,
    input  logic [dpe_pkg::CONC_W-1:0]    i_immob_conc,
    input  logic [dpe_pkg::POR_W-1:0]     i_mobile_porosity,
    input  logic [dpe_pkg::POR_W-1:0]     i_immob_porosity,
    input  logic [dpe_pkg::CONC_W-1:0]    i_exchange_rate,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [dpe_pkg::CONC_W-1:0]    o_new_mobile_conc,
    output logic [dpe_pkg::CONC_W-1:0]    o_new_immob_conc,
    output logic                          o_exchanged,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dpe_pkg::CONC_W-1:0]    i_cfg_data
);

    localparam int VX  = 4 + dpe_pkg::DIV_STAGES;
    localparam int LAT = VX + 1 + dpe_pkg::EXP_LAT + 2;

    logic                         w_en;
    logic [LAT-1:0]               r_vld;
    logic [dpe_pkg::CONC_W-1:0]   r_time_step;

    logic [dpe_pkg::CONC_W-1:0]   r_cm;
    logic [dpe_pkg::CONC_W-1:0]   r_ci;
    logic [dpe_pkg::POR_W-1:0]    r_pm;
    logic [dpe_pkg::POR_W-1:0]    r_pi;
    logic [dpe_pkg::CONC_W-1:0]   r_alpha;

    dpe_pkg::t_s2                 n_s2, r_s2;
    dpe_pkg::t_s3                 n_s3, r_s3;
    dpe_pkg::t_div                n_div0;
    dpe_pkg::t_div                r_div [dpe_pkg::DIV_STAGES+1];
    dpe_pkg::t_side               n_sx, r_sx;
    logic [dpe_pkg::X_W-1:0]      n_x, r_x;
    dpe_pkg::t_side               r_side [dpe_pkg::EXP_LAT];
    logic [dpe_pkg::S_W-1:0]      w_s;
    dpe_pkg::t_rlx                n_rlx, r_rlx;

    logic [dpe_pkg::CONC_W-1:0]   n_out_m, n_out_i, r_out_m, r_out_i, r_out_avg;
    logic                         n_out_x, r_out_x;

    logic [dpe_pkg::T_FULL_W-1:0] w_t;
    logic [dpe_pkg::E_W-1:0]      w_e;
    logic [dpe_pkg::CONC_W-1:0]   w_dm, w_di, w_mag_m, w_mag_i;
    logic [dpe_pkg::Q_W-1:0]      w_q2;

    function automatic dpe_pkg::t_div div_step(input dpe_pkg::t_div d);
        dpe_pkg::t_div           o;
        logic [dpe_pkg::R1_W:0]  s1;
        logic [dpe_pkg::R2_W:0]  s2;
        int                      b;
        o = d;
        for (b = 0; b < dpe_pkg::DIV_BITS; b++) begin
            s1    = {o.r1, o.lo1[dpe_pkg::Q_W-1]};
            o.lo1 = o.lo1 << 1;
            if (s1 >= (dpe_pkg::R1_W+1)'(o.den)) begin
                s1   = s1 - (dpe_pkg::R1_W+1)'(o.den);
                o.q1 = {o.q1[dpe_pkg::Q_W-2:0], 1'b1};
            end else begin
                o.q1 = {o.q1[dpe_pkg::Q_W-2:0], 1'b0};
            end
            o.r1  = s1[dpe_pkg::R1_W-1:0];
            s2    = {o.r2, o.lo2[dpe_pkg::Q_W-1]};
            o.lo2 = o.lo2 << 1;
            if (s2 >= (dpe_pkg::R2_W+1)'(o.pmpi)) begin
                s2   = s2 - (dpe_pkg::R2_W+1)'(o.pmpi);
                o.q2 = {o.q2[dpe_pkg::Q_W-2:0], 1'b1};
            end else begin
                o.q2 = {o.q2[dpe_pkg::Q_W-2:0], 1'b0};
            end
            o.r2  = s2[dpe_pkg::R2_W-1:0];
        end
        return o;
    endfunction

    assign w_en        = !r_vld[LAT-1] || i_out_ready;
    assign o_in_ready  = w_en && i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign o_out_valid = r_vld[LAT-1];
    assign o_new_mobile_conc = r_out_m;
    assign o_new_immob_conc  = r_out_i;
    assign o_exchanged       = r_out_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_time_step <= dpe_pkg::TS_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_time_step <= i_cfg_data;
            end
            if (w_en) begin
                r_vld <= {r_vld[LAT-2:0], i_in_valid};
            end
        end
    end

    always_comb begin
        n_s2.cm   = r_cm;
        n_s2.ci   = r_ci;
        n_s2.pmcm = dpe_pkg::PROD_W'(r_pm) * dpe_pkg::PROD_W'(r_cm);
        n_s2.pici = dpe_pkg::PROD_W'(r_pi) * dpe_pkg::PROD_W'(r_ci);
        n_s2.den  = dpe_pkg::DEN_W'(r_pm) + dpe_pkg::DEN_W'(r_pi);
        n_s2.ad   = dpe_pkg::AD_W'(r_alpha) * dpe_pkg::AD_W'(r_time_step);
        n_s2.pmpi = dpe_pkg::PP_W'(r_pm) * dpe_pkg::PP_W'(r_pi);
        n_s2.pass = (r_pi == '0);
        n_s2.pmz  = (r_pm == '0);
    end

    always_comb begin
        w_t       = r_s2.ad[dpe_pkg::AD_W-1:dpe_pkg::FRAC_BITS];
        n_s3.cm   = r_s2.cm;
        n_s3.ci   = r_s2.ci;
        n_s3.num  = dpe_pkg::NUM_W'(r_s2.pmcm) + dpe_pkg::NUM_W'(r_s2.pici)
                    + dpe_pkg::NUM_W'(r_s2.den >> 1);
        n_s3.tden = dpe_pkg::TDEN_W'(w_t[dpe_pkg::T_W-1:0]) * dpe_pkg::TDEN_W'(r_s2.den);
        n_s3.den  = r_s2.den;
        n_s3.pmpi = r_s2.pmpi;
        n_s3.tcap = (w_t >= dpe_pkg::T_FULL_W'(dpe_pkg::XCAP));
        n_s3.pass = r_s2.pass;
        n_s3.pmz  = r_s2.pmz;
    end

    always_comb begin
        n_div0.cm   = r_s3.cm;
        n_div0.ci   = r_s3.ci;
        n_div0.pass = r_s3.pass;
        n_div0.pmz  = r_s3.pmz;
        n_div0.tcap = r_s3.tcap;
        n_div0.den  = r_s3.den;
        n_div0.pmpi = r_s3.pmpi;
        n_div0.r1   = dpe_pkg::R1_W'(r_s3.num >> dpe_pkg::Q_W);
        n_div0.lo1  = r_s3.num[dpe_pkg::Q_W-1:0];
        n_div0.q1   = '0;
        n_div0.r2   = dpe_pkg::R2_W'(r_s3.tden[dpe_pkg::TDEN_W-1:dpe_pkg::XSH]);
        n_div0.lo2  = {r_s3.tden[dpe_pkg::XSH-1:0], dpe_pkg::XSH'(0)};
        n_div0.q2   = '0;
        n_div0.ovf  = (dpe_pkg::R2_W'(r_s3.tden[dpe_pkg::TDEN_W-1:dpe_pkg::XSH])
                       >= dpe_pkg::R2_W'(r_s3.pmpi));
    end

    always_comb begin
        w_q2      = r_div[dpe_pkg::DIV_STAGES].q2;
        n_sx.cm   = r_div[dpe_pkg::DIV_STAGES].cm;
        n_sx.ci   = r_div[dpe_pkg::DIV_STAGES].ci;
        n_sx.avg  = r_div[dpe_pkg::DIV_STAGES].q1;
        n_sx.pass = r_div[dpe_pkg::DIV_STAGES].pass || (r_div[dpe_pkg::DIV_STAGES].q1 == '0);
        n_sx.pmz  = r_div[dpe_pkg::DIV_STAGES].pmz;
        if (r_div[dpe_pkg::DIV_STAGES].tcap || r_div[dpe_pkg::DIV_STAGES].ovf
            || (w_q2 > dpe_pkg::Q_W'(dpe_pkg::XCAP))) begin
            n_x = dpe_pkg::XCAP;
        end else begin
            n_x = w_q2[dpe_pkg::X_W-1:0];
        end
    end

    dpe_exp u_exp (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_x),
        .o_s   (w_s)
    );

    always_comb begin
        if (r_side[dpe_pkg::EXP_LAT-1].pmz) begin
            w_e = '0;
        end else begin
            w_e = dpe_pkg::E_W'((w_s + dpe_pkg::S_W'(1 << (29 - dpe_pkg::FRAC_BITS)))
                                >> (30 - dpe_pkg::FRAC_BITS));
        end
        n_rlx.cm   = r_side[dpe_pkg::EXP_LAT-1].cm;
        n_rlx.ci   = r_side[dpe_pkg::EXP_LAT-1].ci;
        n_rlx.avg  = r_side[dpe_pkg::EXP_LAT-1].avg;
        n_rlx.pass = r_side[dpe_pkg::EXP_LAT-1].pass;
        n_rlx.gm   = (n_rlx.cm >= n_rlx.avg);
        n_rlx.gi   = (n_rlx.ci >= n_rlx.avg);
        w_dm       = n_rlx.gm ? n_rlx.cm - n_rlx.avg : n_rlx.avg - n_rlx.cm;
        w_di       = n_rlx.gi ? n_rlx.ci - n_rlx.avg : n_rlx.avg - n_rlx.ci;
        n_rlx.pmm  = dpe_pkg::PM_W'(w_dm) * dpe_pkg::PM_W'(w_e);
        n_rlx.pmi  = dpe_pkg::PM_W'(w_di) * dpe_pkg::PM_W'(w_e);
    end

    always_comb begin
        w_mag_m = dpe_pkg::CONC_W'((r_rlx.pmm + dpe_pkg::PM_W'(1 << (dpe_pkg::FRAC_BITS - 1)))
                                   >> dpe_pkg::FRAC_BITS);
        w_mag_i = dpe_pkg::CONC_W'((r_rlx.pmi + dpe_pkg::PM_W'(1 << (dpe_pkg::FRAC_BITS - 1)))
                                   >> dpe_pkg::FRAC_BITS);
        if (r_rlx.pass) begin
            n_out_m = r_rlx.cm;
            n_out_i = r_rlx.ci;
            n_out_x = 1'b0;
        end else begin
            n_out_m = r_rlx.gm ? r_rlx.avg + w_mag_m : r_rlx.avg - w_mag_m;
            n_out_i = r_rlx.gi ? r_rlx.avg + w_mag_i : r_rlx.avg - w_mag_i;
            n_out_x = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cm      <= i_mobile_conc;
            r_ci      <= i_immob_conc;
            r_pm      <= i_mobile_porosity;
            r_pi      <= i_immob_porosity;
            r_alpha   <= i_exchange_rate;
            r_s2      <= n_s2;
            r_s3      <= n_s3;
            r_div[0]  <= n_div0;
            for (int i = 0; i < dpe_pkg::DIV_STAGES; i++) begin
                r_div[i+1] <= div_step(r_div[i]);
            end
            r_sx      <= n_sx;
            r_x       <= n_x;
            r_side[0] <= r_sx;
            for (int i = 1; i < dpe_pkg::EXP_LAT; i++) begin
                r_side[i] <= r_side[i-1];
            end
            r_rlx     <= n_rlx;
            r_out_m   <= n_out_m;
            r_out_i   <= n_out_i;
            r_out_x   <= n_out_x;
            r_out_avg <= r_rlx.avg;
        end
    end

    `DPE_ASSERT_IMPL(a_x_clamped, r_vld[VX], r_x <= dpe_pkg::XCAP, "exponent above cap")
    `DPE_ASSERT_IMPL(a_sides_of_avg, o_out_valid && o_exchanged,
        ((r_out_m >= r_out_avg) && (r_out_i <= r_out_avg))
        || ((r_out_m <= r_out_avg) && (r_out_i >= r_out_avg)),
        "results on the same side of the average")
    `DPE_ASSERT_NEXT(a_valid_advance, w_en, o_out_valid == $past(r_vld[LAT-2]),
        "valid bit lost or invented at the output stage")

endmodule

FILE: sv/dpe_exp.sv
module dpe_exp (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [dpe_pkg::X_W-1:0]   i_x,
    output logic [dpe_pkg::S_W-1:0]   o_s
);

    logic [dpe_pkg::U_W-1:0]  r_ua [dpe_pkg::EXP_TERMS];
    logic [dpe_pkg::U_W-1:0]  r_ub [dpe_pkg::EXP_TERMS];
    logic [dpe_pkg::U_W-1:0]  r_uc [dpe_pkg::EXP_TERMS];
    logic [dpe_pkg::M_W-1:0]  r_m  [dpe_pkg::EXP_TERMS];
    logic [dpe_pkg::P_W-1:0]  r_p  [dpe_pkg::EXP_TERMS];
    logic [dpe_pkg::PQ_W-1:0] r_pq [dpe_pkg::EXP_TERMS];
    logic [dpe_pkg::S_W-1:0]  r_sc [dpe_pkg::EXP_TERMS];
    logic [dpe_pkg::S_W-1:0]  r_sq [dpe_pkg::SQUARINGS];

    // Each series term takes three stages: product, reciprocal product, correction.
    for (genvar j = 0; j < dpe_pkg::EXP_TERMS; j++) begin : g_term
        localparam int K = dpe_pkg::EXP_TERMS - j;
        localparam logic [dpe_pkg::RCP_W-1:0] RCP = dpe_pkg::recip(K);
        logic [dpe_pkg::U_W-1:0]  u_in;
        logic [dpe_pkg::S_W-1:0]  s_in;
        logic [dpe_pkg::P_W-1:0]  n_p;
        logic [dpe_pkg::P_W-1:0]  q_est;
        logic [dpe_pkg::P_W+3:0]  rem;
        logic [dpe_pkg::P_W-1:0]  n_q;

        if (j == 0) begin : g_first
            assign u_in = dpe_pkg::U_W'(i_x) << (24 - dpe_pkg::FRAC_BITS);
            assign s_in = dpe_pkg::ONE30;
        end else begin : g_next
            assign u_in = r_uc[j-1];
            assign s_in = r_sc[j-1];
        end

        always_comb begin
            n_p   = dpe_pkg::P_W'(r_m[j] >> 30);
            q_est = dpe_pkg::P_W'(r_pq[j] >> 32);
            rem   = (dpe_pkg::P_W+4)'(r_p[j])
                    - (dpe_pkg::P_W+4)'(q_est) * (dpe_pkg::P_W+4)'(K);
            n_q   = (rem >= (dpe_pkg::P_W+4)'(K)) ? q_est + 1'b1 : q_est;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m[j]  <= dpe_pkg::M_W'(u_in) * dpe_pkg::M_W'(s_in);
                r_ua[j] <= u_in;
                r_pq[j] <= dpe_pkg::PQ_W'(n_p) * dpe_pkg::PQ_W'(RCP);
                r_p[j]  <= n_p;
                r_ub[j] <= r_ua[j];
                r_sc[j] <= dpe_pkg::ONE30 - dpe_pkg::S_W'(n_q);
                r_uc[j] <= r_ub[j];
            end
        end
    end

    for (genvar i = 0; i < dpe_pkg::SQUARINGS; i++) begin : g_sq
        logic [dpe_pkg::S_W-1:0]  s_in;
        logic [dpe_pkg::SQ_W-1:0] sq;

        if (i == 0) begin : g_first
            assign s_in = r_sc[dpe_pkg::EXP_TERMS-1];
        end else begin : g_next
            assign s_in = r_sq[i-1];
        end

        assign sq = dpe_pkg::SQ_W'(s_in) * dpe_pkg::SQ_W'(s_in) + dpe_pkg::HALF30;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[i] <= dpe_pkg::S_W'(sq >> 30);
            end
        end
    end

    assign o_s = r_sq[dpe_pkg::SQUARINGS-1];

endmodule
